### rtl/wlts_pkg.sv
// ----------------------------------------------------------------------------
// Windowed linear trend smoother - shared package
// Widths, payload types, sequencer codes and status structs for the block.
// ----------------------------------------------------------------------------
package wlts_pkg;

  localparam int WIN_MAX     = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_W     = 6;
  localparam int VU_W      = 6;
  localparam int LEN_RESET = 16;
  localparam int MIN_FIT   = 2;

  localparam int CNT_W  = $clog2(WIN_MAX + 1);
  localparam int PTR_W  = $clog2(WIN_MAX);
  localparam int WSUM_W = PTR_W + 1;
  localparam int ENT_W  = SAMPLE_BITS + 1;

  // accumulator widths, sized for a full window of full-scale samples
  localparam int SX_W  = $clog2(WIN_MAX * (WIN_MAX + 1) / 2 + 1);
  localparam int SXX_W = $clog2(WIN_MAX * (WIN_MAX + 1) * (2 * WIN_MAX + 1) / 6 + 1);
  localparam int SY_W  = SAMPLE_BITS + CNT_W;
  localparam int SXY_W = SAMPLE_BITS + SX_W;

  // fit terms
  localparam int BSXX_W = CNT_W + SXX_W;
  localparam int BSXY_W = CNT_W + SXY_W + 1;
  localparam int DIFF_W = SX_W + 1;
  localparam int NUM_W  = ((SY_W + BSXX_W) > (BSXY_W + DIFF_W) ?
                           (SY_W + BSXX_W) : (BSXY_W + DIFF_W)) + 1;
  localparam int DEN_W  = CNT_W + BSXX_W;

  // shared multiplier
  localparam int MA_W = BSXY_W;
  localparam int MB_W = BSXX_W + 1;
  localparam int MP_W = MA_W + MB_W;

  // serial divider
  localparam int DSH_W  = DEN_W + SAMPLE_BITS;
  localparam int REM_W  = ((NUM_W - 1) > DSH_W) ? (NUM_W - 1) : DSH_W;
  localparam int QUO_W  = SAMPLE_BITS + 1;
  localparam int DCNT_W = $clog2(QUO_W + 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] motion_sample;
    logic                   sample_missing;
  } wlts_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smoothed_motion;
    logic [VU_W-1:0]        valid_used;
  } wlts_out_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] idx;   // age of the entry, 0 is newest
  } wlts_rd_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] quo;   // already saturated
  } wlts_div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } wlts_state_e;

  // multiplier steps: each step but the last issues one product, each but the first captures the previous one
  typedef enum logic [2:0] {
    MS_NSXX,   // issue n*sxx
    MS_SXSX,   // issue sx*sx
    MS_NSXY,   // Sxx ready, issue n*sxy
    MS_SXSY,   // issue sx*sy
    MS_SYBX,   // Sxy ready, issue sy*Sxx
    MS_BXYD,   // issue Sxy*(n-sx)
    MS_NBX,    // numerator ready, issue n*Sxx
    MS_DEN     // denominator on the product
  } wlts_mstep_e;

endpackage

### rtl/wlts_window.sv
// ----------------------------------------------------------------------------
// Sample window store
// Circular buffer of valid/sample entries, read by age with registered data.
// ----------------------------------------------------------------------------
module wlts_window (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [wlts_pkg::ENT_W-1:0] wr_data_i,
  input  wlts_pkg::wlts_rd_req_t    rd_req_i,
  output logic [wlts_pkg::ENT_W-1:0] rd_data_o
);
  import wlts_pkg::*;

  logic [ENT_W-1:0]  mem_q [WIN_MAX];
  logic [ENT_W-1:0]  rd_q;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [WSUM_W-1:0] rd_sum;

  // head_q points at the newest entry
  always_comb begin
    wr_addr = (head_q == PTR_W'(WIN_MAX - 1)) ? '0 : head_q + 1'b1;
    head_d  = wr_en_i ? wr_addr : head_q;
    rd_sum  = {1'b0, head_q} + WSUM_W'(WIN_MAX) - {1'b0, rd_req_i.idx};
    if (rd_sum >= WSUM_W'(WIN_MAX)) begin
      rd_addr = PTR_W'(rd_sum - WSUM_W'(WIN_MAX));
    end else begin
      rd_addr = PTR_W'(rd_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/wlts_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed product with a register on the output, reused for every fit term.
// ----------------------------------------------------------------------------
module wlts_mul (
  input  logic                             clk_i,
  input  logic signed [wlts_pkg::MA_W-1:0] a_i,
  input  logic signed [wlts_pkg::MB_W-1:0] b_i,
  output logic signed [wlts_pkg::MP_W-1:0] p_o
);
  import wlts_pkg::*;

  logic signed [MP_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MP_W'(a_i) * MP_W'(b_i);
  end

  assign p_o = p_q;

endmodule

### rtl/wlts_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit a cycle; the extra top bit flags
// saturation.
// ----------------------------------------------------------------------------
module wlts_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wlts_pkg::NUM_W-2:0]   num_i,
  input  logic [wlts_pkg::DEN_W-1:0]   den_i,
  output wlts_pkg::wlts_div_sts_t      sts_o
);
  import wlts_pkg::*;

  logic [REM_W-1:0]  rem_q;
  logic [REM_W-1:0]  dsh_q;
  logic [QUO_W-1:0]  quo_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic              ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(num_i);
      dsh_q <= REM_W'(den_i) << SAMPLE_BITS;
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.quo  = quo_q[QUO_W-1] ? '1 : quo_q[SAMPLE_BITS-1:0];

endmodule

### rtl/windowed_linear_trend_smoother_unit.sv
// The divide is skipped when there are under two valid entries or a fit that is not
// positive. The next input beat is taken no sooner than the result: walk of one
// entry a cycle, 8 multiplier steps, then the serial divide.
// Reset: fill count cleared, window_length back to 16; window storage
// is not cleared, entries past the fill count are never read.
// ----------------------------------------------------------------------------
// Windowed linear trend smoother
// Least-squares line over the recent samples, evaluated at the newest one.
// ----------------------------------------------------------------------------
module windowed_linear_trend_smoother_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  wlts_pkg::wlts_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output wlts_pkg::wlts_out_t          out_data_o,
  input  logic                         cfg_we_i,
  input  logic [wlts_pkg::CFG_W-1:0]   cfg_data_i
);
  import wlts_pkg::*;

  wlts_state_e  state_q, state_d;
  wlts_mstep_e  step_q, step_d;

  logic [CFG_W-1:0] cfg_len_q;
  logic [CNT_W-1:0] len_eff;
  logic [CNT_W:0]   fill_inc;
  logic [CNT_W-1:0] fill_q, fill_next;

  logic             accept;
  logic             rd_pend_q;
  logic [PTR_W-1:0] idx_q;
  logic [CNT_W-1:0] x_q;

  logic [CNT_W-1:0] n_q;
  logic [SX_W-1:0]  sx_q;
  logic [SXX_W-1:0] sxx_q, x_sq;
  logic [SY_W-1:0]  sy_q, sy_inc;
  logic [SXY_W-1:0] sxy_q;

  logic signed [NUM_W-1:0]  t1_q;
  logic [BSXX_W-1:0]        bsxx_q;
  logic signed [BSXY_W-1:0] bsxy_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [DIFF_W-1:0] diff;
  logic                     fit_go;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  wlts_rd_req_t     rd_req;
  logic [ENT_W-1:0] win_rd;
  logic             ent_valid;

  logic             div_start;
  wlts_div_sts_t    div_sts;

  logic [SAMPLE_BITS-1:0] res_q;
  wlts_out_t              out_q;
  logic                   out_vld_q;
  logic                   out_load;

  // --------------------------------------------------------------------------
  // window length and fill
  always_comb begin
    if (cfg_len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(cfg_len_q) > WIN_MAX) begin
      len_eff = CNT_W'(WIN_MAX);
    end else begin
      len_eff = CNT_W'(cfg_len_q);
    end
    fill_inc  = {1'b0, fill_q} + 1'b1;
    fill_next = (fill_inc < {1'b0, len_eff}) ? CNT_W'(fill_inc) : len_eff;
  end

  assign diff   = DIFF_W'(n_q) - DIFF_W'(sx_q);
  assign fit_go = (n_q >= CNT_W'(MIN_FIT)) && (num_q > 0);

  // --------------------------------------------------------------------------
  // sequencer: next state
  always_comb begin
    state_d = state_q;
    step_d  = MS_NSXX;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (idx_q == '0) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        step_d = wlts_mstep_e'(step_q + 1'b1);
        if (step_q == MS_DEN) begin
          state_d = fit_go ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_sts.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    rd_req.en  = (state_q == ST_WALK);
    rd_req.idx = idx_q;
    div_start  = (state_q == ST_MUL) && (step_q == MS_DEN) && fit_go;
    out_load   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);
    mul_a      = '0;
    mul_b      = '0;
    case (step_q)
      MS_NSXX: begin
        mul_a = MA_W'(sxx_q);
        mul_b = MB_W'(n_q);
      end
      MS_SXSX: begin
        mul_a = MA_W'(sx_q);
        mul_b = MB_W'(sx_q);
      end
      MS_NSXY: begin
        mul_a = MA_W'(sxy_q);
        mul_b = MB_W'(n_q);
      end
      MS_SXSY: begin
        mul_a = MA_W'(sy_q);
        mul_b = MB_W'(sx_q);
      end
      MS_SYBX: begin
        mul_a = MA_W'(sy_q);
        mul_b = MB_W'(bsxx_q);
      end
      MS_BXYD: begin
        mul_a = MA_W'(bsxy_q);
        mul_b = MB_W'(diff);
      end
      MS_NBX: begin
        mul_a = MA_W'(bsxx_q);
        mul_b = MB_W'(n_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= MS_NSXX;
      cfg_len_q <= CFG_W'(LEN_RESET);
      fill_q    <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      rd_pend_q <= rd_req.en;
      if (cfg_we_i) cfg_len_q <= cfg_data_i;
      if (accept) fill_q <= fill_next;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // accumulation, walked oldest to newest: sxy gathers the running sum of y
  assign ent_valid = win_rd[ENT_W-1];
  assign sy_inc    = sy_q + (ent_valid ? SY_W'(win_rd[SAMPLE_BITS-1:0]) : '0);
  assign x_sq      = SXX_W'(x_q) * SXX_W'(x_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= PTR_W'(fill_next - 1'b1);
      n_q   <= '0;
      sx_q  <= '0;
      sxx_q <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
    end else begin
      if (rd_req.en) begin
        idx_q <= idx_q - 1'b1;
        x_q   <= CNT_W'(idx_q) + 1'b1;
      end
      if (rd_pend_q) begin
        sy_q  <= sy_inc;
        sxy_q <= sxy_q + SXY_W'(sy_inc);
        if (ent_valid) begin
          n_q   <= n_q + 1'b1;
          sx_q  <= sx_q + SX_W'(x_q);
          sxx_q <= sxx_q + x_sq;
        end
      end
    end

    if (state_q == ST_MUL) begin
      case (step_q)
        MS_SXSX: t1_q   <= NUM_W'(mul_p);
        MS_NSXY: bsxx_q <= BSXX_W'(t1_q - mul_p);
        MS_SXSY: t1_q   <= NUM_W'(mul_p);
        MS_SYBX: bsxy_q <= BSXY_W'(t1_q - mul_p);
        MS_BXYD: t1_q   <= NUM_W'(mul_p);
        MS_NBX:  num_q  <= NUM_W'(t1_q + mul_p);
        MS_DEN: begin
          if (!fit_go) res_q <= '0;
        end
        default: t1_q <= t1_q;
      endcase
    end
    if ((state_q == ST_DIV) && div_sts.done) begin
      res_q <= div_sts.quo;
    end
    if (out_load) begin
      out_q.smoothed_motion <= res_q;
      out_q.valid_used      <= VU_W'(n_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  wlts_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i ({~in_data_i.sample_missing, in_data_i.motion_sample}),
    .rd_req_i  (rd_req),
    .rd_data_o (win_rd)
  );

  wlts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wlts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q[NUM_W-2:0]),
    .den_i   (mul_p[DEN_W-1:0]),
    .sts_o   (div_sts)
  );

  // --------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_WALK) && (fill_q != '0))
    else $error("accepted beat did not start a window walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_WALK) || (state_q == ST_DRAIN))
    else $error("window read data arrived outside the walk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (n_q >= CNT_W'(MIN_FIT)))
    else $error("division started with too few valid entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.valid_used < VU_W'(MIN_FIT)))
      |-> (out_data_o.smoothed_motion == '0))
    else $error("nonzero trend from fewer than two valid entries");

endmodule
